/* hdl/zbti_pkg.sv */
// Package for the zoned bilinear table interpolator.
// Holds the transfer payload types, fixed-point constants and zone grid tables.
// No dependencies.
package zbti_pkg;

    localparam int TABLE_DEPTH_DEF = 262144;
    localparam int WORD_BITS_DEF   = 32;
    localparam int ZONES           = 7;

    localparam logic [29:0]        HBARC_Q32     = 30'd847512745;
    localparam logic signed [31:0] INV_HBARC_Q28 = 32'sd1360358898;
    localparam logic [16:0]        ONE_Q16       = 17'd65536;

    localparam logic REG_ODD_IN_DENSITY = 1'b0;
    localparam logic REG_RAW_OUTPUT     = 1'b1;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [17:0]        table_address;
        logic signed [31:0] table_word;
        logic [39:0]        energy_density;
        logic signed [35:0] charge_density;
    } in_t;

    typedef struct packed {
        logic signed [31:0] interpolated_value;
        logic [2:0]         energy_zone;
        logic               density_clamped;
    } out_t;

    localparam logic [38:0] ZONE_START [ZONES] = '{
        39'd0, 39'd241592, 39'd1006633, 39'd3019899,
        39'd30534533, 39'd1366000927, 39'd14720664863
    };
    localparam logic [33:0] ZONE_INV_E [ZONES] = '{
        34'd13981013333, 34'd6990506667, 34'd4194304000, 34'd419430400,
        34'd41943040, 34'd4194304, 34'd419430
    };
    localparam logic [7:0] ZONE_ROWS [ZONES] = '{
        8'd13, 8'd20, 8'd31, 8'd42, 8'd200, 8'd200, 8'd200
    };
    localparam logic [8:0] ZONE_COLS [ZONES] = '{
        9'd500, 9'd300, 9'd180, 9'd250, 9'd350, 9'd250, 9'd200
    };
    localparam logic [38:0] ZONE_INV_R [ZONES] = '{
        39'd419430400000, 39'd83886080000, 39'd16777216000, 39'd2097152000,
        39'd419430400, 39'd83886080, 39'd20971520
    };
    localparam logic [35:0] ZONE_BOUND [ZONES] = '{
        36'd1336809, 36'd3999688, 36'd11945378, 36'd133143986,
        36'd934155387, 36'd3328599654, 36'd10630044058
    };
    localparam logic [17:0] ZONE_BASE [ZONES] = '{
        18'd0, 18'd6500, 18'd12500, 18'd18080, 18'd28580, 18'd98580, 18'd148580
    };

endpackage

/* hdl/zoned_bilinear_table_interpolator.sv */
// Zoned bilinear table interpolator, pipelined from input transfer to result, takes one
// item per cycle unless the output stalls; a write item takes one table word and gives
// no result. Four neighbour reads a cycle, unless stalled, come from two table copies
// with two read ports each. aresetn (synchronous, active low) clears valid bits and
// both config registers; the table is not cleared and holds garbage until written.
// Depends on zbti_pkg.
module zoned_bilinear_table_interpolator #(
    parameter int TABLE_DEPTH = zbti_pkg::TABLE_DEPTH_DEF,
    parameter int WORD_BITS   = zbti_pkg::WORD_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic           cfg_index,
    input  logic           cfg_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  zbti_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output zbti_pkg::out_t m_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int FULL_W = (ADDR_W > 19) ? ADDR_W + 1 : 20;
    localparam int MEM_W  = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int NSTG   = 15;

    typedef struct packed {
        logic               lookup;
        logic               neg;
        logic [17:0]        addr;
        logic signed [31:0] word;
        logic [2:0]         zone;
        logic               clamped;
    } ctl_t;

    logic                en;
    logic [NSTG-1:0]     vld_reg;
    logic                m_valid_reg;
    logic                odd_reg;
    logic                raw_reg;

    zbti_pkg::in_t       in1_reg;
    ctl_t                ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg, ctl6_reg, ctl7_reg, ctl8_reg;
    ctl_t                ctl9_reg, ctl10_reg, ctl11_reg, ctl12_reg, ctl13_reg, ctl14_reg;
    ctl_t                ctl15_reg;
    ctl_t                ctl2_next, ctl4_next, ctl5_next;

    logic [49:0]         ephi2_reg, eplo2_reg;
    logic [35:0]         rmag2_reg, rmag3_reg, rmag4_reg, rmag5_reg;
    logic [35:0]         rmag2_next;
    logic [50:0]         esum3;
    logic [38:0]         e0_3_reg, e0_4_reg, off5_reg;
    logic [53:0]         pehi6_reg;
    logic [52:0]         pelo6_reg;
    logic [56:0]         prhi6_reg, prlo6_reg;
    logic [72:0]         esum7;
    logic [74:0]         rsum7;
    logic [40:0]         pose7_reg, posr7_reg;
    logic [24:0]         mraw8, nraw8;
    logic [7:0]          m8_reg, m8_next;
    logic [8:0]          n8_reg, n8_next;
    logic [16:0]         fx8_reg, fx8_next, fy8_reg, fy8_next;
    logic [16:0]         wx0, wy0, mc9;
    logic [FULL_W-1:0]   a9_reg, a9_next;
    logic [8:0]          cols9_reg;
    logic [32:0]         wt9_reg [4];
    logic [32:0]         wt10_reg [4];
    logic [FULL_W-1:0]   rd_addr [4];
    logic [FULL_W-1:0]   wr_addr;
    logic                wr_en;
    logic [MEM_W-1:0]    mem_a [TABLE_DEPTH];
    logic [MEM_W-1:0]    mem_b [TABLE_DEPTH];
    logic [MEM_W-1:0]    rdq10_reg [4];
    logic [3:0]          inr10_reg;
    logic signed [31:0]  qs [4];
    logic signed [65:0]  prod11_reg [4];
    logic signed [66:0]  s01_12_reg, s23_12_reg;
    logic signed [67:0]  tot13;
    logic signed [35:0]  v13_reg, v14_reg;
    logic signed [67:0]  sc14_reg, scr15;
    logic signed [39:0]  w15_reg, w15_next, nv16;
    zbti_pkg::out_t      out_reg, out_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[NSTG-2:0], s_valid};
            m_valid_reg <= vld_reg[NSTG-1] && (ctl15_reg.lookup == zbti_pkg::REQ_LOOKUP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            odd_reg <= 1'b0;
            raw_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                zbti_pkg::REG_ODD_IN_DENSITY: odd_reg <= cfg_wdata;
                zbti_pkg::REG_RAW_OUTPUT:     raw_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage 2: split energy product, density magnitude
    always_comb begin
        ctl2_next.lookup  = in1_reg.req_type;
        ctl2_next.neg     = in1_reg.charge_density[35];
        ctl2_next.addr    = in1_reg.table_address;
        ctl2_next.word    = in1_reg.table_word;
        ctl2_next.zone    = 3'd0;
        ctl2_next.clamped = 1'b0;
        rmag2_next = in1_reg.charge_density[35] ? (36'd0 - in1_reg.charge_density)
                                                : in1_reg.charge_density;
    end

    // stage 3: scaled energy
    assign esum3 = {1'b0, ephi2_reg} + {21'd0, eplo2_reg[49:20]};

    // stage 4: zone pick
    always_comb begin
        ctl4_next = ctl3_reg;
        for (int j = 1; j < zbti_pkg::ZONES; j++) begin
            if (e0_3_reg >= zbti_pkg::ZONE_START[j]) begin
                ctl4_next.zone = 3'(j);
            end
        end
    end

    // stage 5: zone offset and density bound
    always_comb begin
        ctl5_next         = ctl4_reg;
        ctl5_next.clamped = rmag4_reg > zbti_pkg::ZONE_BOUND[ctl4_reg.zone];
    end

    // stage 7: combine partial products
    assign esum7 = {pehi6_reg, 19'd0} + {20'd0, pelo6_reg};
    assign rsum7 = {prhi6_reg, 18'd0} + {18'd0, prlo6_reg};

    // stage 8: indices and fractions with edge saturation
    assign mraw8 = pose7_reg[40:16];
    assign nraw8 = posr7_reg[40:16];
    always_comb begin
        if (mraw8 >= {17'd0, zbti_pkg::ZONE_ROWS[ctl7_reg.zone]} - 25'd1) begin
            m8_next  = zbti_pkg::ZONE_ROWS[ctl7_reg.zone] - 8'd2;
            fx8_next = zbti_pkg::ONE_Q16;
        end else begin
            m8_next  = mraw8[7:0];
            fx8_next = {1'b0, pose7_reg[15:0]};
        end
        if (ctl7_reg.clamped ||
            nraw8 >= {16'd0, zbti_pkg::ZONE_COLS[ctl7_reg.zone]} - 25'd1) begin
            n8_next  = zbti_pkg::ZONE_COLS[ctl7_reg.zone] - 9'd2;
            fy8_next = zbti_pkg::ONE_Q16;
        end else begin
            n8_next  = nraw8[8:0];
            fy8_next = {1'b0, posr7_reg[15:0]};
        end
    end

    // stage 9: base address and weights
    assign mc9     = 17'(m8_reg) * 17'(zbti_pkg::ZONE_COLS[ctl8_reg.zone]);
    assign a9_next = FULL_W'(zbti_pkg::ZONE_BASE[ctl8_reg.zone]) + FULL_W'(mc9)
                   + FULL_W'(n8_reg);
    assign wx0     = zbti_pkg::ONE_Q16 - fx8_reg;
    assign wy0     = zbti_pkg::ONE_Q16 - fy8_reg;

    // stage 10: table access
    assign rd_addr[0] = a9_reg;
    assign rd_addr[1] = a9_reg + FULL_W'(1);
    assign rd_addr[2] = a9_reg + FULL_W'(cols9_reg);
    assign rd_addr[3] = a9_reg + FULL_W'(cols9_reg) + FULL_W'(1);
    assign wr_addr    = FULL_W'(ctl9_reg.addr);
    assign wr_en      = en && vld_reg[8] && (ctl9_reg.lookup == zbti_pkg::REQ_WRITE)
                     && (wr_addr < FULL_W'(TABLE_DEPTH));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_a[wr_addr[ADDR_W-1:0]] <= ctl9_reg.word[MEM_W-1:0];
            mem_b[wr_addr[ADDR_W-1:0]] <= ctl9_reg.word[MEM_W-1:0];
        end
        if (en) begin
            rdq10_reg[0] <= mem_a[rd_addr[0][ADDR_W-1:0]];
            rdq10_reg[1] <= mem_a[rd_addr[1][ADDR_W-1:0]];
            rdq10_reg[2] <= mem_b[rd_addr[2][ADDR_W-1:0]];
            rdq10_reg[3] <= mem_b[rd_addr[3][ADDR_W-1:0]];
        end
    end

    // stage 11: weighted corners
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qs[i] = inr10_reg[i] ? 32'($signed(rdq10_reg[i])) : 32'sd0;
        end
    end

    // stage 13: blend with rounding
    assign tot13 = s01_12_reg + s23_12_reg + 68'sd2147483648;

    // stage 15: hbar-c division with rounding, bypassed in raw output mode
    assign scr15    = sc14_reg + 68'sd134217728;
    assign w15_next = raw_reg ? {{4{v14_reg[35]}}, v14_reg} : scr15[67:28];

    // stage 16: sign and saturation
    always_comb begin
        nv16 = (odd_reg && ctl15_reg.neg) ? -w15_reg : w15_reg;
        out_next.energy_zone     = ctl15_reg.zone;
        out_next.density_clamped = ctl15_reg.clamped;
        priority if (nv16 > 40'sd2147483647) begin
            out_next.interpolated_value = 32'sh7FFFFFFF;
        end else if (nv16 < -40'sd2147483648) begin
            out_next.interpolated_value = 32'sh80000000;
        end else begin
            out_next.interpolated_value = nv16[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in1_reg    <= s_data;

            ctl2_reg   <= ctl2_next;
            ephi2_reg  <= 50'(in1_reg.energy_density[39:20]) * 50'(zbti_pkg::HBARC_Q32);
            eplo2_reg  <= 50'(in1_reg.energy_density[19:0]) * 50'(zbti_pkg::HBARC_Q32);
            rmag2_reg  <= rmag2_next;

            ctl3_reg   <= ctl2_reg;
            e0_3_reg   <= esum3[50:12];
            rmag3_reg  <= rmag2_reg;

            ctl4_reg   <= ctl4_next;
            e0_4_reg   <= e0_3_reg;
            rmag4_reg  <= rmag3_reg;

            ctl5_reg   <= ctl5_next;
            off5_reg   <= e0_4_reg - zbti_pkg::ZONE_START[ctl4_reg.zone];
            rmag5_reg  <= rmag4_reg;

            ctl6_reg   <= ctl5_reg;
            pehi6_reg  <= 54'(off5_reg[38:19]) * 54'(zbti_pkg::ZONE_INV_E[ctl5_reg.zone]);
            pelo6_reg  <= 53'(off5_reg[18:0]) * 53'(zbti_pkg::ZONE_INV_E[ctl5_reg.zone]);
            prhi6_reg  <= 57'(rmag5_reg[35:18]) * 57'(zbti_pkg::ZONE_INV_R[ctl5_reg.zone]);
            prlo6_reg  <= 57'(rmag5_reg[17:0]) * 57'(zbti_pkg::ZONE_INV_R[ctl5_reg.zone]);

            ctl7_reg   <= ctl6_reg;
            pose7_reg  <= esum7[72:32];
            posr7_reg  <= rsum7[74:34];

            ctl8_reg   <= ctl7_reg;
            m8_reg     <= m8_next;
            n8_reg     <= n8_next;
            fx8_reg    <= fx8_next;
            fy8_reg    <= fy8_next;

            ctl9_reg   <= ctl8_reg;
            a9_reg     <= a9_next;
            cols9_reg  <= zbti_pkg::ZONE_COLS[ctl8_reg.zone];
            wt9_reg[0] <= 33'(wx0) * 33'(wy0);
            wt9_reg[1] <= 33'(wx0) * 33'(fy8_reg);
            wt9_reg[2] <= 33'(fx8_reg) * 33'(wy0);
            wt9_reg[3] <= 33'(fx8_reg) * 33'(fy8_reg);

            ctl10_reg  <= ctl9_reg;
            for (int i = 0; i < 4; i++) begin
                wt10_reg[i]  <= wt9_reg[i];
                inr10_reg[i] <= rd_addr[i] < FULL_W'(TABLE_DEPTH);
            end

            ctl11_reg  <= ctl10_reg;
            for (int i = 0; i < 4; i++) begin
                prod11_reg[i] <= qs[i] * $signed({1'b0, wt10_reg[i]});
            end

            ctl12_reg  <= ctl11_reg;
            s01_12_reg <= prod11_reg[0] + prod11_reg[1];
            s23_12_reg <= prod11_reg[2] + prod11_reg[3];

            ctl13_reg  <= ctl12_reg;
            v13_reg    <= tot13[67:32];

            ctl14_reg  <= ctl13_reg;
            v14_reg    <= v13_reg;
            sc14_reg   <= v13_reg * zbti_pkg::INV_HBARC_Q28;

            ctl15_reg  <= ctl14_reg;
            w15_reg    <= w15_next;

            out_reg    <= out_next;
        end
    end

endmodule
